// ===== src/dlsg_pkg.sv =====
// ----------------------------------------------------------------------------
// dlsg_pkg
// Shared types and constants of the dashed line segment generator: input and
// result words, and the command word that runs from front end to walker.
// ----------------------------------------------------------------------------
`default_nettype none

package dlsg_pkg;

  localparam int CoordBits     = 12;
  localparam int PatternLength = 16;
  localparam int PatternBits   = 16;
  localparam int PhaseBits     = 4;
  localparam int ColorBits     = 16;
  localparam int ErrBits       = CoordBits + 2;
  localparam int CmdDepth      = 2;
  localparam int ResDepth      = 2;

  typedef enum logic {
    MODE_START = 1'b0,
    MODE_STEP  = 1'b1
  } mode_e;

  typedef logic [CoordBits-1:0] coord_t;

  typedef struct packed {
    logic                   mode;
    coord_t                 start_x;
    coord_t                 start_y;
    coord_t                 end_x;
    coord_t                 end_y;
    logic [PatternBits-1:0] dash_pattern;
    logic [PhaseBits-1:0]   phase;
    logic [ColorBits-1:0]   color;
  } in_item_t;

  typedef struct packed {
    logic                 segment_valid;
    coord_t               seg_start_x;
    coord_t               seg_start_y;
    coord_t               seg_end_x;
    coord_t               seg_end_y;
    logic [ColorBits-1:0] seg_color;
    logic                 line_done;
    logic [PhaseBits-1:0] next_phase;
  } out_item_t;

  // classified item with the line setup already worked out
  typedef struct packed {
    logic                       is_start;
    coord_t                     start_x;
    coord_t                     start_y;
    coord_t                     end_x;
    coord_t                     end_y;
    coord_t                     dist_x;
    logic signed [CoordBits:0]  neg_dist_y;
    logic                       step_x_neg;
    logic                       step_y_neg;
    logic signed [ErrBits-1:0]  error_term;
    logic [PatternBits-1:0]     dash_pattern;
    logic [PhaseBits-1:0]       phase;
    logic [ColorBits-1:0]       color;
  } cmd_t;

endpackage

`default_nettype wire

// ===== src/dashed_line_segment_generator_core.sv =====
// ----------------------------------------------------------------------------
// dashed_line_segment_generator_core
// Bresenham line walker with a 16-step dash pattern that reports dash runs.
// ----------------------------------------------------------------------------
// Input words are written with push while full is low. A start word (mode 0)
// loads endpoints, pattern, phase and color and drops any line in progress;
// each step word (mode 1) walks one pixel. Step words while no line is open
// are dropped. A result word appears when a dash run closes or when the last
// pixel is walked (line_done with the phase that follows); it is read from
// out_item_o while empty is low and taken with pop.
// A pushed word is registered in the command queue, then walked, and its
// result word is registered in the result queue, where it can be popped.
// Throughput is one word per clock while the result queue takes results, set
// by the walker step (two adds and two compares on the error term). A
// two-word queue sits in front of the walker and another behind it; when the
// receiver stalls the result queue fills, the walker holds at the next word
// that reports, the command queue fills and full rises. Reset empties both
// queues and leaves the walker with no line open.
// ----------------------------------------------------------------------------
`default_nettype none

module dashed_line_segment_generator_core #(
  parameter int CmdDepth = dlsg_pkg::CmdDepth,
  parameter int ResDepth = dlsg_pkg::ResDepth
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push,
  output logic                     full,
  input  wire dlsg_pkg::in_item_t  in_item_i,
  output logic                     empty,
  input  wire logic                pop,
  output dlsg_pkg::out_item_t      out_item_o
);

  dlsg_pkg::cmd_t      cmd_in, cmd_out;
  logic                cmd_empty, cmd_pop;
  dlsg_pkg::out_item_t res_word;
  logic                res_push, res_full;

  dlsg_front u_front (
    .in_item_i (in_item_i),
    .cmd_o     (cmd_in)
  );

  dlsg_fifo #(
    .T     (dlsg_pkg::cmd_t),
    .Depth (CmdDepth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .empty_o (cmd_empty)
  );

  dlsg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_out),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_o       (res_word),
    .res_push_o  (res_push),
    .res_full_i  (res_full)
  );

  dlsg_fifo #(
    .T     (dlsg_pkg::out_item_t),
    .Depth (ResDepth)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_word),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (out_item_o),
    .empty_o (empty)
  );

endmodule

`default_nettype wire

// ===== src/dlsg_fifo.sv =====
// ----------------------------------------------------------------------------
// dlsg_fifo
// Small register queue with push/full and pop/empty, first word on data_o
// while not empty.
// ----------------------------------------------------------------------------
`default_nettype none

module dlsg_fifo #(
  parameter type T     = logic,
  parameter int  Depth = 2
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire T     data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output T          data_o,
  output logic      empty_o
);

  localparam int PtrBits = $clog2(Depth);
  localparam int CntBits = $clog2(Depth + 1);

  T                     mem_q [Depth];
  logic [PtrBits-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrBits-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntBits-1:0]   count_q, count_d;
  logic                 wr_en, rd_en;

  assign full_o  = (count_q == CntBits'(Depth));
  assign empty_o = (count_q == '0);
  assign wr_en   = push_i && !full_o;
  assign rd_en   = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == PtrBits'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == PtrBits'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en && !rd_en) begin
      count_d = count_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== src/dlsg_front.sv =====
// ----------------------------------------------------------------------------
// dlsg_front
// Classifies an input word as line start or pixel step and works out the
// line setup (distances, step directions, initial error) for a start.
// ----------------------------------------------------------------------------
`default_nettype none

module dlsg_front (
  input  wire dlsg_pkg::in_item_t in_item_i,
  output dlsg_pkg::cmd_t          cmd_o
);

  logic             x_fwd, y_fwd;
  dlsg_pkg::coord_t dx, dy;

  assign x_fwd = in_item_i.start_x < in_item_i.end_x;
  assign y_fwd = in_item_i.start_y < in_item_i.end_y;
  assign dx    = x_fwd ? in_item_i.end_x - in_item_i.start_x
                       : in_item_i.start_x - in_item_i.end_x;
  assign dy    = y_fwd ? in_item_i.end_y - in_item_i.start_y
                       : in_item_i.start_y - in_item_i.end_y;

  always_comb begin
    cmd_o.is_start     = (in_item_i.mode == dlsg_pkg::MODE_START);
    cmd_o.start_x      = in_item_i.start_x;
    cmd_o.start_y      = in_item_i.start_y;
    cmd_o.end_x        = in_item_i.end_x;
    cmd_o.end_y        = in_item_i.end_y;
    cmd_o.dist_x       = dx;
    cmd_o.neg_dist_y   = -$signed({1'b0, dy});
    cmd_o.step_x_neg   = !x_fwd;
    cmd_o.step_y_neg   = !y_fwd;
    cmd_o.error_term   = $signed({2'b00, dx}) - $signed({2'b00, dy});
    cmd_o.dash_pattern = in_item_i.dash_pattern;
    cmd_o.phase        = dlsg_pkg::PhaseBits'(in_item_i.phase % dlsg_pkg::PatternLength);
    cmd_o.color        = in_item_i.color;
  end

endmodule

`default_nettype wire

// ===== src/dlsg_back.sv =====
// ----------------------------------------------------------------------------
// dlsg_back
// Line walker: one Bresenham pixel per step word, dash pattern test, run
// tracking and segment / end-of-line reporting.
// ----------------------------------------------------------------------------
`default_nettype none

module dlsg_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire dlsg_pkg::cmd_t cmd_i,
  input  wire logic           cmd_empty_i,
  output logic                cmd_pop_o,
  output dlsg_pkg::out_item_t res_o,
  output logic                res_push_o,
  input  wire logic           res_full_i
);

  localparam int CoordBits = dlsg_pkg::CoordBits;
  localparam int ErrBits   = dlsg_pkg::ErrBits;
  localparam int PhaseBits = dlsg_pkg::PhaseBits;

  logic busy_q, busy_d;
  logic run_open_q, run_open_d;

  dlsg_pkg::coord_t                 cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  dlsg_pkg::coord_t                 tgt_x_q, tgt_x_d, tgt_y_q, tgt_y_d;
  dlsg_pkg::coord_t                 dist_x_q, dist_x_d;
  logic signed [CoordBits:0]        neg_dist_y_q, neg_dist_y_d;
  logic                             step_x_neg_q, step_x_neg_d;
  logic                             step_y_neg_q, step_y_neg_d;
  logic signed [ErrBits-1:0]        error_q, error_d;
  logic [dlsg_pkg::PatternBits-1:0] pattern_q, pattern_d;
  logic [PhaseBits-1:0]             phase_q, phase_d;
  dlsg_pkg::coord_t                 run_sx_q, run_sx_d, run_sy_q, run_sy_d;
  dlsg_pkg::coord_t                 run_ex_q, run_ex_d, run_ey_q, run_ey_d;
  logic [dlsg_pkg::ColorBits-1:0]   color_q, color_d;

  logic                 is_step, bit_on, last_pixel, emit, go;
  logic                 step_x, step_y;
  logic signed [ErrBits:0] e2;
  logic [PhaseBits-1:0] phase_nxt;

  assign is_step    = !cmd_i.is_start && busy_q;
  assign bit_on     = pattern_q[phase_q];
  assign last_pixel = (cur_x_q == tgt_x_q) && (cur_y_q == tgt_y_q);
  assign phase_nxt  = (phase_q == PhaseBits'(dlsg_pkg::PatternLength - 1))
                    ? '0 : phase_q + 1'b1;
  assign e2         = $signed({error_q, 1'b0});
  assign step_x     = e2 >= (ErrBits+1)'(neg_dist_y_q);
  assign step_y     = e2 <= $signed({{(ErrBits+1-CoordBits){1'b0}}, dist_x_q});

  // a step reports when it closes a run or reaches the end of the line
  assign emit       = is_step && ((!bit_on && run_open_q) || last_pixel);
  assign go         = !cmd_empty_i && !(emit && res_full_i);
  assign cmd_pop_o  = go;
  assign res_push_o = go && emit;

  // result word
  always_comb begin
    res_o = '0;
    if (!bit_on && run_open_q) begin
      res_o.segment_valid = 1'b1;
      res_o.seg_start_x   = run_sx_q;
      res_o.seg_start_y   = run_sy_q;
      res_o.seg_end_x     = run_ex_q;
      res_o.seg_end_y     = run_ey_q;
      res_o.seg_color     = color_q;
    end else if (bit_on && last_pixel) begin
      res_o.segment_valid = 1'b1;
      res_o.seg_start_x   = run_open_q ? run_sx_q : cur_x_q;
      res_o.seg_start_y   = run_open_q ? run_sy_q : cur_y_q;
      res_o.seg_end_x     = cur_x_q;
      res_o.seg_end_y     = cur_y_q;
      res_o.seg_color     = color_q;
    end
    if (last_pixel) begin
      res_o.line_done  = 1'b1;
      res_o.next_phase = phase_nxt;
    end
  end

  // next state
  always_comb begin
    busy_d       = busy_q;
    run_open_d   = run_open_q;
    cur_x_d      = cur_x_q;
    cur_y_d      = cur_y_q;
    tgt_x_d      = tgt_x_q;
    tgt_y_d      = tgt_y_q;
    dist_x_d     = dist_x_q;
    neg_dist_y_d = neg_dist_y_q;
    step_x_neg_d = step_x_neg_q;
    step_y_neg_d = step_y_neg_q;
    error_d      = error_q;
    pattern_d    = pattern_q;
    phase_d      = phase_q;
    run_sx_d     = run_sx_q;
    run_sy_d     = run_sy_q;
    run_ex_d     = run_ex_q;
    run_ey_d     = run_ey_q;
    color_d      = color_q;
    if (go && cmd_i.is_start) begin
      busy_d       = 1'b1;
      run_open_d   = 1'b0;
      cur_x_d      = cmd_i.start_x;
      cur_y_d      = cmd_i.start_y;
      tgt_x_d      = cmd_i.end_x;
      tgt_y_d      = cmd_i.end_y;
      dist_x_d     = cmd_i.dist_x;
      neg_dist_y_d = cmd_i.neg_dist_y;
      step_x_neg_d = cmd_i.step_x_neg;
      step_y_neg_d = cmd_i.step_y_neg;
      error_d      = cmd_i.error_term;
      pattern_d    = cmd_i.dash_pattern;
      phase_d      = cmd_i.phase;
      color_d      = cmd_i.color;
    end else if (go && is_step) begin
      phase_d = phase_nxt;
      if (bit_on) begin
        if (!run_open_q) begin
          run_sx_d = cur_x_q;
          run_sy_d = cur_y_q;
        end
        run_ex_d   = cur_x_q;
        run_ey_d   = cur_y_q;
        run_open_d = !last_pixel;
      end else begin
        run_open_d = 1'b0;
      end
      if (last_pixel) begin
        busy_d = 1'b0;
      end else begin
        error_d = error_q
                + (step_x ? ErrBits'(neg_dist_y_q) : ErrBits'(0))
                + (step_y ? $signed({2'b00, dist_x_q}) : ErrBits'(0));
        if (step_x) begin
          cur_x_d = step_x_neg_q ? cur_x_q - 1'b1 : cur_x_q + 1'b1;
        end
        if (step_y) begin
          cur_y_d = step_y_neg_q ? cur_y_q - 1'b1 : cur_y_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      run_open_q <= 1'b0;
    end else begin
      busy_q     <= busy_d;
      run_open_q <= run_open_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_x_q      <= cur_x_d;
    cur_y_q      <= cur_y_d;
    tgt_x_q      <= tgt_x_d;
    tgt_y_q      <= tgt_y_d;
    dist_x_q     <= dist_x_d;
    neg_dist_y_q <= neg_dist_y_d;
    step_x_neg_q <= step_x_neg_d;
    step_y_neg_q <= step_y_neg_d;
    error_q      <= error_d;
    pattern_q    <= pattern_d;
    phase_q      <= phase_d;
    run_sx_q     <= run_sx_d;
    run_sy_q     <= run_sy_d;
    run_ex_q     <= run_ex_d;
    run_ey_q     <= run_ey_d;
    color_q      <= color_d;
  end

endmodule

`default_nettype wire

// ===== dv/dlsg_checker.sv =====
// ----------------------------------------------------------------------------
// dlsg_checker
// Scoreboard for the dashed line segment generator: walks its own copy of
// the line from every accepted input word and compares each popped result
// word against the oldest predicted one.
// ----------------------------------------------------------------------------
module dlsg_checker
  import dlsg_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  logic      full_i,
  input  in_item_t  in_item_i,
  input  logic      empty_i,
  input  logic      pop_i,
  input  out_item_t out_item_i,
  output int        errors_o,
  output int        pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // walker state of the prediction
  logic                      line_open;
  coord_t                    pix_x, pix_y, goal_x, goal_y;
  coord_t                    span_x;
  logic signed [CoordBits:0] neg_span_y;
  logic                      back_x, back_y;
  logic signed [ErrBits-1:0] err_acc;
  logic [PatternBits-1:0]    dash_bits;
  logic [PhaseBits-1:0]      dash_phase;
  logic                      dash_open;
  coord_t                    dash_x0, dash_y0, dash_x1, dash_y1;
  logic [ColorBits-1:0]      pen_color;

  out_item_t segment_q[$];

  function automatic string fmt_word(out_item_t r);
    return $sformatf("seg=%0b (%0d,%0d)-(%0d,%0d) color=%h done=%0b phase=%0d",
                     r.segment_valid, r.seg_start_x, r.seg_start_y, r.seg_end_x,
                     r.seg_end_y, r.seg_color, r.line_done, r.next_phase);
  endfunction

  task automatic walk_word(input in_item_t w);
    out_item_t r;
    logic      emit;
    coord_t    ady;
    int        e2;
    r    = '0;
    emit = 1'b0;
    if (w.mode == MODE_START) begin
      pix_x      = w.start_x;
      pix_y      = w.start_y;
      goal_x     = w.end_x;
      goal_y     = w.end_y;
      span_x     = (w.start_x < w.end_x) ? w.end_x - w.start_x : w.start_x - w.end_x;
      ady        = (w.start_y < w.end_y) ? w.end_y - w.start_y : w.start_y - w.end_y;
      neg_span_y = '0 - $signed({1'b0, ady});
      back_x     = !(w.start_x < w.end_x);
      back_y     = !(w.start_y < w.end_y);
      err_acc    = $signed({2'b00, span_x}) + neg_span_y;
      dash_bits  = w.dash_pattern;
      dash_phase = PhaseBits'(w.phase % PatternLength);
      pen_color  = w.color;
      dash_open  = 1'b0;
      line_open  = 1'b1;
    end else if (line_open) begin
      if (dash_bits[dash_phase]) begin
        if (!dash_open) begin
          dash_x0   = pix_x;
          dash_y0   = pix_y;
          dash_open = 1'b1;
        end
        dash_x1 = pix_x;
        dash_y1 = pix_y;
      end else if (dash_open) begin
        r.segment_valid = 1'b1;
        r.seg_start_x   = dash_x0;
        r.seg_start_y   = dash_y0;
        r.seg_end_x     = dash_x1;
        r.seg_end_y     = dash_y1;
        r.seg_color     = pen_color;
        dash_open       = 1'b0;
        emit            = 1'b1;
      end
      dash_phase = (dash_phase == PatternLength - 1) ? '0 : dash_phase + 1'b1;
      if (pix_x == goal_x && pix_y == goal_y) begin
        if (dash_open) begin
          r.segment_valid = 1'b1;
          r.seg_start_x   = dash_x0;
          r.seg_start_y   = dash_y0;
          r.seg_end_x     = dash_x1;
          r.seg_end_y     = dash_y1;
          r.seg_color     = pen_color;
          dash_open       = 1'b0;
        end
        r.line_done  = 1'b1;
        r.next_phase = dash_phase;
        line_open    = 1'b0;
        emit         = 1'b1;
      end else begin
        e2 = 2 * int'(err_acc);
        if (e2 >= int'(neg_span_y)) begin
          err_acc = err_acc + neg_span_y;
          pix_x   = back_x ? pix_x - 1'b1 : pix_x + 1'b1;
        end
        if (e2 <= int'(span_x)) begin
          err_acc = err_acc + $signed({2'b00, span_x});
          pix_y   = back_y ? pix_y - 1'b1 : pix_y + 1'b1;
        end
      end
    end
    if (emit) segment_q.push_back(r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      line_open  = 1'b0;
      pix_x      = '0;
      pix_y      = '0;
      goal_x     = '0;
      goal_y     = '0;
      span_x     = '0;
      neg_span_y = '0;
      back_x     = 1'b0;
      back_y     = 1'b0;
      err_acc    = '0;
      dash_bits  = '0;
      dash_phase = '0;
      dash_open  = 1'b0;
      dash_x0    = '0;
      dash_y0    = '0;
      dash_x1    = '0;
      dash_y1    = '0;
      pen_color  = '0;
      segment_q.delete();
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (push_i && !full_i) walk_word(in_item_i);
      if (pop_i && !empty_i) begin
        if (segment_q.size() == 0) begin
          if (errors_o < 10) $display("unexpected result word: %s", fmt_word(out_item_i));
          errors_o <= errors_o + 1;
        end else begin
          want = segment_q.pop_front();
          if (out_item_i !== want) begin
            if (errors_o < 10) begin
              $display("result mismatch at %0t", $realtime);
              $display("  expected %s", fmt_word(want));
              $display("  actual   %s", fmt_word(out_item_i));
            end
            errors_o <= errors_o + 1;
          end
        end
      end
      pending_o <= segment_q.size();
    end
  end

endmodule

// ===== dv/tb_dashed_line_segment_generator_core.sv =====
// ----------------------------------------------------------------------------
// tb_dashed_line_segment_generator_core
// Drives start and step words into the line walker with random gaps and
// back-pressure; the checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module tb_dashed_line_segment_generator_core;
  timeunit 1ns;
  timeprecision 1ps;
  import dlsg_pkg::*;

  localparam int CoordMax  = (1 << CoordBits) - 1;
  localparam int WordCount = 1450;
  localparam int HoldLen   = 300;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      push      = 1'b0;
  logic      pop       = 1'b0;
  in_item_t  in_item_i = '0;
  logic      full;
  logic      empty;
  out_item_t out_item_o;

  int errors;
  int pending;
  int words_sent = 0;
  int hold_req   = 0;
  int hold_done  = 0;
  logic quiet    = 1'b0;

  dashed_line_segment_generator_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item_i),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );

  dlsg_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_i     (full),
    .in_item_i  (in_item_i),
    .empty_i    (empty),
    .pop_i      (pop),
    .out_item_i (out_item_o),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("dashed_line_segment_generator_core test failed");
    $finish;
  end

  // receiver: random pops, plus one long hold-off when requested
  initial begin
    int n;
    forever begin
      @(posedge clk_i);
      if (hold_req != hold_done) begin
        hold_done = hold_req;
        for (n = 0; n < HoldLen; n++) begin
          pop <= 1'b0;
          @(posedge clk_i);
        end
      end
      pop <= quiet ? 1'b1 : ($urandom_range(99) >= 23);
    end
  end

  function automatic in_item_t start_word(int sx, int sy, int ex, int ey,
                                          logic [PatternBits-1:0] pat,
                                          logic [PhaseBits-1:0] ph,
                                          logic [ColorBits-1:0] col);
    in_item_t w;
    w.mode         = MODE_START;
    w.start_x      = coord_t'(sx);
    w.start_y      = coord_t'(sy);
    w.end_x        = coord_t'(ex);
    w.end_y        = coord_t'(ey);
    w.dash_pattern = pat;
    w.phase        = ph;
    w.color        = col;
    return w;
  endfunction

  // step word with junk in the unused fields
  function automatic in_item_t step_word();
    logic [95:0] junk;
    in_item_t    w;
    junk   = {$urandom, $urandom, $urandom};
    w      = junk[$bits(in_item_t)-1:0];
    w.mode = MODE_STEP;
    return w;
  endfunction

  function automatic int rand_coord();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) return 0;
    if (pick < 20) return CoordMax;
    return $urandom_range(CoordMax);
  endfunction

  // move d away from c in a random direction, staying on the grid
  function automatic int offset_coord(int c, int d);
    int r;
    r = $urandom_range(1) ? c + d : c - d;
    if (r > CoordMax || r < 0) r = 2 * c - r;
    return r;
  endfunction

  task automatic send_word(input in_item_t w);
    quiet = (words_sent >= 1000 && words_sent < 1250);
    while (!quiet && $urandom_range(99) < 23) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push      <= 1'b1;
    in_item_i <= w;
    do @(posedge clk_i); while (full);
    words_sent++;
  endtask

  task automatic send_line(input in_item_t s, input int steps);
    send_word(s);
    repeat (steps) send_word(step_word());
  endtask

  task automatic wait_for_results();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic send_random_line();
    int pick, d, ddx, ddy, sx, sy, steps;
    logic [PatternBits-1:0] pat;
    pick = $urandom_range(99);
    if (pick < 70) d = $urandom_range(12);
    else if (pick < 95) d = $urandom_range(60, 13);
    else d = $urandom_range(300, 61);
    ddx = $urandom_range(d);
    ddy = $urandom_range(d);
    if ($urandom_range(1)) ddx = d;
    else ddy = d;
    sx = rand_coord();
    sy = rand_coord();
    pick = $urandom_range(99);
    if (pick < 10) pat = '0;
    else if (pick < 20) pat = '1;
    else if (pick < 35) pat = PatternBits'($urandom & $urandom);
    else pat = PatternBits'($urandom);
    steps = ((ddx > ddy) ? ddx : ddy) + 1;
    pick = $urandom_range(99);
    // cut short so the next start drops the line, or overrun into idle steps
    if (pick < 10) steps = steps - $urandom_range(steps, 1);
    else if (pick < 15) steps = steps + $urandom_range(3, 1);
    send_line(start_word(sx, sy, offset_coord(sx, ddx), offset_coord(sy, ddy), pat,
                         PhaseBits'($urandom), ColorBits'($urandom)), steps);
  endtask

  initial begin
    int pick;
    logic held;
    logic paused;
    held   = 1'b0;
    paused = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed corners
    send_word(step_word());
    send_line(start_word(0, 0, 0, 0, 16'hFFFF, 4'd0, 16'hFFFF), 1);
    send_line(start_word(CoordMax, CoordMax, CoordMax, CoordMax, 16'h0000, 4'd15,
                         16'h0000), 1);
    send_line(start_word(0, CoordMax, 4, CoordMax - 2, 16'hAAAA, 4'd0, 16'h1234), 5);
    send_line(start_word(CoordMax, 0, CoordMax - 3, 3, 16'h8001, 4'd15, 16'h5A5A), 4);
    send_line(start_word(10, 10, 20, 15, 16'hFFFF, 4'd3, 16'h0F0F), 2);
    send_line(start_word(100, 200, 98, 200, 16'h00FF, 4'd7, 16'hF0F0), 3);
    wait_for_results();

    while (words_sent < WordCount) begin
      if (!held && words_sent >= 400) begin
        // long receiver stall while the sender keeps pushing a dense line
        held = 1'b1;
        hold_req++;
        send_line(start_word(200, 300, 299, 340, 16'h0F0F, 4'd0, 16'hBEEF), 100);
      end
      if (!paused && words_sent >= 800) begin
        paused = 1'b1;
        wait_for_results();
      end
      pick = $urandom_range(99);
      if (pick < 80) begin
        send_random_line();
      end else if (pick < 90) begin
        repeat ($urandom_range(3, 1)) send_word(step_word());
      end else begin
        send_word(start_word(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                             PatternBits'($urandom), PhaseBits'($urandom),
                             ColorBits'($urandom)));
        send_random_line();
      end
    end

    wait_for_results();
    repeat (10) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("dashed_line_segment_generator_core test passed");
    end else begin
      $display("dashed_line_segment_generator_core test failed");
    end
    $finish;
  end

endmodule
